@@ rtl/ppu_pkg.sv @@
// ----------------------------------------------------------------------------
// Particle pool update package
// Shared types, codes and saturating helpers for the particle pool core.
// ----------------------------------------------------------------------------
package ppu_pkg;

    // Number of particle slots; the slot and count fields are sized for it.
    localparam int POOL_DEPTH = 64;

    // Request codes on the input channel.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_GRAVITY_X  = 2'd1;
    localparam logic [1:0] CFG_GRAVITY_Y  = 2'd2;
    localparam logic [1:0] CFG_GRAVITY_Z  = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_AGE,
        S_COPY,
        S_MUL,
        S_ACC,
        S_WB,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT
    } t_state;

    // Add a floored Q16.16 product (product bits [52:16]) to a 32-bit value,
    // clamping at the signed 32-bit bounds.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [36:0] b);
        logic signed [37:0] s;
        s = {{6{a[31]}}, a} + {b[36], b};
        if (s > 38'sh0_7FFF_FFFF) begin
            sat_add = 32'sh7FFF_FFFF;
        end else if (s < -38'sh0_8000_0000) begin
            sat_add = 32'sh8000_0000;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    // Unsigned age sum, clamping at all ones.
    function automatic logic [31:0] sat_age(input logic [31:0] a,
                                            input logic [19:0] dt);
        logic [32:0] s;
        s = {1'b0, a} + {13'd0, dt};
        sat_age = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/ppu_in_if.sv @@
// ----------------------------------------------------------------------------
// Particle pool request channel
// Valid/ready channel carrying add and tick requests.
// ----------------------------------------------------------------------------
interface ppu_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] speed_x;
    logic [31:0] speed_y;
    logic [31:0] speed_z;
    logic [31:0] life_span;
    logic [19:0] step_time;

    modport source (output valid, req_type, start_x, start_y, start_z,
                    speed_x, speed_y, speed_z, life_span, step_time,
                    input ready);
    modport sink (input valid, req_type, start_x, start_y, start_z,
                  speed_x, speed_y, speed_z, life_span, step_time,
                  output ready);
endinterface

@@ rtl/ppu_out_if.sv @@
// ----------------------------------------------------------------------------
// Particle pool result channel
// Valid/ready channel carrying add status and particle records.
// ----------------------------------------------------------------------------
interface ppu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        accepted;
    logic [5:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] age_now;
    logic [6:0]  live_count;
    logic        last;

    modport source (output valid, kind, accepted, slot, pos_x, pos_y, pos_z,
                    age_now, live_count, last, input ready);
    modport sink (input valid, kind, accepted, slot, pos_x, pos_y, pos_z,
                  age_now, live_count, last, output ready);
endinterface

@@ rtl/particle_pool_update_core.sv @@
// ----------------------------------------------------------------------------
// Particle pool update core
// Stores particles and steps them with one shared multiplier.
// ----------------------------------------------------------------------------
// An add transaction is handled in the idle state and then waits for the
// result to be taken. A tick transaction walks every particle in slot
// order: a live particle takes one memory read, an age check, six multiply
// and accumulate pairs on the single shared multiplier and one write back; a
// dying particle is replaced by a copy of the last one and its slot is then
// examined again. The records are then read back one at a time, each through
// a memory read, a load into the output register and the output wait. The core
// accepts no new transaction until the last result of the current one has
// been taken.
module particle_pool_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ppu_in_if.sink      i_req,
    ppu_out_if.source   o_res
);
    import ppu_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);

    // Configuration registers.
    logic [6:0]         r_max_active;
    logic signed [31:0] r_grav [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_active <= 7'd64;
            r_grav[0]    <= '0;
            r_grav[1]    <= '0;
            r_grav[2]    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ACTIVE: r_max_active <= i_cfg_data[6:0];
                CFG_GRAVITY_X:  r_grav[0]    <= i_cfg_data;
                CFG_GRAVITY_Y:  r_grav[1]    <= i_cfg_data;
                CFG_GRAVITY_Z:  r_grav[2]    <= i_cfg_data;
                default:        r_max_active <= r_max_active;
            endcase
        end
    end

    // Particle memories: one read and one write address per cycle.
    logic signed [31:0] m_pos [3][POOL_DEPTH];
    logic signed [31:0] m_vel [3][POOL_DEPTH];
    logic [31:0]        m_age [POOL_DEPTH];
    logic [31:0]        m_life [POOL_DEPTH];

    logic               mem_we;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      rd_addr;
    logic signed [31:0] wd_pos [3];
    logic signed [31:0] wd_vel [3];
    logic [31:0]        wd_age;
    logic [31:0]        wd_life;
    logic signed [31:0] rd_pos [3];
    logic signed [31:0] rd_vel [3];
    logic [31:0]        rd_age;
    logic [31:0]        rd_life;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (mem_we) begin
                m_pos[c][wr_addr] <= wd_pos[c];
                m_vel[c][wr_addr] <= wd_vel[c];
            end
            rd_pos[c] <= m_pos[c][rd_addr];
            rd_vel[c] <= m_vel[c][rd_addr];
        end
        if (mem_we) begin
            m_age[wr_addr]  <= wd_age;
            m_life[wr_addr] <= wd_life;
        end
        rd_age  <= m_age[rd_addr];
        rd_life <= m_life[rd_addr];
    end

    // Sequencer and working registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_i, n_i;
    logic [19:0]        r_dt, n_dt;
    logic [2:0]         r_step, n_step;
    logic               r_emit, n_emit;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] n_vel [3];
    logic [31:0]        r_age, n_age;
    logic signed [52:0] r_prod, n_prod;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_kind, n_kind;
    logic        r_acc, n_acc;
    logic [5:0]  r_slot, n_slot;
    logic [31:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic [31:0] r_oage, n_oage;
    logic [6:0]  r_live, n_live;
    logic        r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_emit   <= 1'b0;
            r_i      <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_emit   <= n_emit;
            r_i      <= n_i;
            r_step   <= n_step;
        end
        r_dt   <= n_dt;
        r_pos  <= n_pos;
        r_vel  <= n_vel;
        r_age  <= n_age;
        r_prod <= n_prod;
        r_kind <= n_kind;
        r_acc  <= n_acc;
        r_slot <= n_slot;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oz   <= n_oz;
        r_oage <= n_oage;
        r_live <= n_live;
        r_last <= n_last;
    end

    // Shared multiplier operands, the step's component and derived pool values.
    logic [1:0]         comp;
    logic signed [31:0] mul_a;
    logic signed [20:0] mul_b;
    logic [31:0]        age_sum;
    logic               pool_full;
    logic [CW-1:0]      last_idx;

    assign comp      = r_step[2:1];
    assign mul_b     = $signed({1'b0, r_dt});
    assign age_sum   = sat_age(rd_age, r_dt);
    assign last_idx  = r_count - CW'(1);
    assign pool_full = (16'(r_count) >= 16'(r_max_active)) ||
                       (16'(r_count) >= 16'(POOL_DEPTH));

    always_comb begin
        mul_a = r_vel[comp];
        if (!r_step[0]) begin
            mul_a = r_grav[comp];
        end
    end

    // Next state and datapath control.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_dt     = r_dt;
        n_step   = r_step;
        n_emit   = r_emit;
        n_pos    = r_pos;
        n_vel    = r_vel;
        n_age    = r_age;
        n_prod   = r_prod;
        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_slot   = r_slot;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oz     = r_oz;
        n_oage   = r_oage;
        n_live   = r_live;
        n_last   = r_last;
        mem_we   = 1'b0;
        wr_addr  = r_i[IW-1:0];
        rd_addr  = r_i[IW-1:0];
        wd_pos   = r_pos;
        wd_vel   = r_vel;
        wd_age   = r_age;
        wd_life  = rd_life;
        i_req.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_dt = i_req.step_time;
                    n_i  = '0;
                    if (i_req.req_type == REQ_TICK) begin
                        n_state = S_WALK;
                    end else begin
                        n_emit   = 1'b0;
                        n_kind   = KIND_ADD;
                        n_oage   = '0;
                        n_last   = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_OUT;
                        if (pool_full) begin
                            n_acc  = 1'b0;
                            n_slot = '0;
                            n_ox   = '0;
                            n_oy   = '0;
                            n_oz   = '0;
                            n_live = 7'(r_count);
                        end else begin
                            mem_we    = 1'b1;
                            wr_addr   = r_count[IW-1:0];
                            wd_pos[0] = i_req.start_x;
                            wd_pos[1] = i_req.start_y;
                            wd_pos[2] = i_req.start_z;
                            wd_vel[0] = i_req.speed_x;
                            wd_vel[1] = i_req.speed_y;
                            wd_vel[2] = i_req.speed_z;
                            wd_age    = '0;
                            wd_life   = i_req.life_span;
                            n_count   = r_count + CW'(1);
                            n_acc     = 1'b1;
                            n_slot    = 6'(r_count);
                            n_ox      = i_req.start_x;
                            n_oy      = i_req.start_y;
                            n_oz      = i_req.start_z;
                            n_live    = 7'(r_count + CW'(1));
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_i < r_count) begin
                    n_state = S_AGE;
                end else if (r_count == '0) begin
                    n_emit   = 1'b0;
                    n_kind   = KIND_EMPTY;
                    n_acc    = 1'b0;
                    n_slot   = '0;
                    n_ox     = '0;
                    n_oy     = '0;
                    n_oz     = '0;
                    n_oage   = '0;
                    n_live   = '0;
                    n_last   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_AGE: begin
                // A dying particle is replaced by the last one in the pool.
                if (age_sum > rd_life) begin
                    rd_addr = last_idx[IW-1:0];
                    n_state = S_COPY;
                end else begin
                    n_pos   = rd_pos;
                    n_vel   = rd_vel;
                    n_age   = age_sum;
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_COPY: begin
                mem_we  = 1'b1;
                wd_pos  = rd_pos;
                wd_vel  = rd_vel;
                wd_age  = rd_age;
                wd_life = rd_life;
                n_count = last_idx;
                n_state = S_WALK;
            end
            S_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ACC;
            end
            S_ACC: begin
                // Even steps update velocity, odd steps position.
                if (!r_step[0]) begin
                    n_vel[comp] = sat_add(r_vel[comp], r_prod[52:16]);
                end else begin
                    n_pos[comp] = sat_add(r_pos[comp], r_prod[52:16]);
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_WB: begin
                mem_we  = 1'b1;
                wd_life = rd_life;
                n_i     = r_i + CW'(1);
                n_state = S_WALK;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_emit   = 1'b1;
                n_kind   = KIND_RECORD;
                n_acc    = 1'b0;
                n_slot   = 6'(r_i);
                n_ox     = rd_pos[0];
                n_oy     = rd_pos[1];
                n_oz     = rd_pos[2];
                n_oage   = rd_age;
                n_live   = 7'(r_count);
                n_last   = (r_i == last_idx);
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_ovalid = 1'b0;
                    if (r_emit && !r_last) begin
                        n_i     = r_i + CW'(1);
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result channel drive.
    assign o_res.valid      = r_ovalid;
    assign o_res.kind       = r_kind;
    assign o_res.accepted   = r_acc;
    assign o_res.slot       = r_slot;
    assign o_res.pos_x      = r_ox;
    assign o_res.pos_y      = r_oy;
    assign o_res.pos_z      = r_oz;
    assign o_res.age_now    = r_oage;
    assign o_res.live_count = r_live;
    assign o_res.last       = r_last;

    // The pool never holds more particles than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        16'(r_count) <= 16'(POOL_DEPTH))
        else $error("pool count beyond depth");

    // A new request is never taken while a result is pending.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request taken with result pending");

    // An add status is always the only result of its transaction.
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_ADD) |-> o_res.last)
        else $error("add status without last");

    // After a request is taken the core is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("ready after accept");

endmodule
